[sv/assert_macros.svh]
// Assertion macros included by the sorted-list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[sv/sortlist_pkg.sv]
`default_nettype none

package sortlist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int OUT_CW   = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  position;
        logic [OUT_CW-1:0] count;
    } t_res;

endpackage

`default_nettype wire

[sv/sortlist_ram.sv]
`default_nettype none

module sortlist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/sorted_list_insert_remove_search.sv]
// Sorted list of up to CAPACITY signed 32-bit values in ascending order.
// A command beat (opcode and value on i_cmd) is taken at a clock edge where
// start is high and busy is low. Insert places the value after equal
// entries, remove deletes the first match, and search reports the first
// match; an unused opcode acts as a search. Each command yields exactly one
// result beat on o_res, marked by o_done for a single cycle; the receiver
// cannot stall it, and the next command may be taken in that same cycle.
// Entries live in a one-port-write, one-port-read RAM with registered read,
// and one comparator walks them. A scan reads and then compares each entry
// visited (S_RD, S_CMP), and the following shift reads and writes each
// entry moved (S_SH_RD, S_SH_WR), ending in a closing S_SH_RD step. The
// result beat comes in the same cycle that busy falls; an insert into a full
// list, or any operation on an empty list, never raises busy and its result
// beat comes in the cycle after the command.
// Reset clears the entry count; the RAM needs no clearing since only
// entries below the count are ever used.
`default_nettype none

module sorted_list_insert_remove_search
    import sortlist_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_res      o_res
);

    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_val, n_val;
    logic               r_done, n_done;
    t_res               r_res, n_res;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [31:0]        ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [31:0]        ram_rdata;
    logic               is_ins;
    logic               last_idx;
    logic               last_j;

    sortlist_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign is_ins   = (r_op == OP_INSERT);
    assign last_idx = ({1'b0, r_idx} + CNT_W'(1)) == r_count;
    assign last_j   = ({1'b0, r_j} + CNT_W'(1)) == r_count;

    always_comb begin
        if (r_state == S_RD) begin
            ram_raddr = r_idx;
        end else if (is_ins) begin
            ram_raddr = r_j - IDX_W'(1);
        end else begin
            ram_raddr = r_j + IDX_W'(1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_j       = r_j;
        n_op      = r_op;
        n_val     = r_val;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_j;
        ram_wdata = ram_rdata;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_cmd.opcode;
                    n_val = i_cmd.value;
                    n_idx = '0;
                    if (i_cmd.opcode == OP_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_done = 1'b1;
                            n_res  = '{ST_FULL, '0, OUT_CW'(r_count)};
                        end else if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = i_cmd.value;
                            n_count   = CNT_W'(1);
                            n_done    = 1'b1;
                            n_res     = '{ST_OK, '0, OUT_CW'(1)};
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (r_count == '0) begin
                        n_done = 1'b1;
                        n_res  = '{ST_NOT_FOUND, '0, '0};
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (is_ins) begin
                    if ($signed(ram_rdata) > r_val) begin
                        n_pos   = r_idx;
                        n_j     = r_count[IDX_W-1:0];
                        n_state = S_SH_RD;
                    end else if (last_idx) begin
                        n_pos   = r_count[IDX_W-1:0];
                        n_j     = r_count[IDX_W-1:0];
                        n_state = S_SH_RD;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end else if (ram_rdata == r_val) begin
                    if (r_op == OP_REMOVE) begin
                        n_pos   = r_idx;
                        n_j     = r_idx;
                        n_state = S_SH_RD;
                    end else begin
                        n_done  = 1'b1;
                        n_res   = '{ST_OK, POS_W'(r_idx), OUT_CW'(r_count)};
                        n_state = S_IDLE;
                    end
                end else if (last_idx) begin
                    n_done  = 1'b1;
                    n_res   = '{ST_NOT_FOUND, '0, OUT_CW'(r_count)};
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                if (is_ins) begin
                    if (r_j == r_pos) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pos;
                        ram_wdata = r_val;
                        n_count   = r_count + CNT_W'(1);
                        n_done    = 1'b1;
                        n_res     = '{ST_OK, POS_W'(r_pos), OUT_CW'(n_count)};
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_SH_WR;
                    end
                end else if (last_j) begin
                    n_count = r_count - CNT_W'(1);
                    n_done  = 1'b1;
                    n_res   = '{ST_OK, POS_W'(r_pos), OUT_CW'(n_count)};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = ram_rdata;
                if (is_ins) begin
                    n_j = r_j - IDX_W'(1);
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
                n_state = S_SH_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_j   <= n_j;
        r_op  <= n_op;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(CAPACITY))
    `ASSERT_SYNC(a_count_moves_with_result, i_clk, i_rst_n, !$stable(r_count) |-> o_done)
    `ASSERT_SYNC(a_done_has_cause, i_clk, i_rst_n, o_done |-> $past(busy) || $past(start))
    `ASSERT_SYNC(a_full_count, i_clk, i_rst_n,
        (o_done && o_res.status == ST_FULL) |-> o_res.count == OUT_CW'(CAPACITY))

endmodule

`default_nettype wire

[tb/tb_sorted_list_insert_remove_search.sv]
`timescale 1ns / 100ps

module tb_sorted_list_insert_remove_search;
    import sortlist_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 1550;
    localparam int PHASE_ITEMS  = (RANDOM_ITEMS + 2) / 3;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 80;

    typedef struct packed {
        t_cmd cmd;
        logic known;
        t_res res;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_cmd i_cmd;
    logic busy;
    logic o_done;
    t_res o_res;

    logic signed [31:0] list_vals [CAPACITY];
    int                 list_len;
    bit                 filling;
    t_res               pending_results [$];
    t_step_row          directed_rows [$];
    t_res               head_res;
    int                 fault_count = 0;
    int                 stall_cycles = 0;

    sorted_list_insert_remove_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_res predict_list_op(t_cmd c);
        t_res r;
        int   pos;
        bit   hit;
        int   i;
        r.status = ST_OK;
        pos = 0;
        hit = 1'b0;
        if (c.opcode == OP_INSERT) begin
            if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = list_len;
                for (i = list_len - 1; i >= 0; i--) begin
                    if ($signed(list_vals[i]) > $signed(c.value)) pos = i;
                end
                for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
                list_vals[pos] = c.value;
                list_len++;
            end
        end else begin
            for (i = list_len - 1; i >= 0; i--) begin
                if (list_vals[i] == c.value) begin
                    hit = 1'b1;
                    pos = i;
                end
            end
            if (!hit) begin
                r.status = ST_NOT_FOUND;
            end else if (c.opcode == OP_REMOVE) begin
                for (i = pos; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
                list_len--;
            end
        end
        if (r.status != ST_OK) pos = 0;
        r.position = pos[POS_W-1:0];
        r.count    = list_len[OUT_CW-1:0];
        return r;
    endfunction

    // Swings between filling and draining so the list reaches both full and empty.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   roll;
        int   pick_pct;
        if (list_len >= CAPACITY) filling = 1'b0;
        if (list_len == 0) filling = 1'b1;
        roll = $urandom_range(99);
        if (filling) begin
            c.opcode = (roll < 60) ? OP_INSERT : (roll < 80) ? OP_REMOVE :
                       (roll < 95) ? OP_SEARCH : OP_UNUSED;
        end else begin
            c.opcode = (roll < 20) ? OP_INSERT : (roll < 75) ? OP_REMOVE :
                       (roll < 95) ? OP_SEARCH : OP_UNUSED;
        end
        pick_pct = (c.opcode == OP_INSERT) ? 25 : 70;
        roll = $urandom_range(99);
        if (list_len > 0 && $urandom_range(99) < pick_pct) begin
            c.value = list_vals[$urandom_range(list_len - 1)];
        end else if (roll < 10) begin
            case ($urandom_range(3))
                0:       c.value = VAL_MIN;
                1:       c.value = VAL_MAX;
                2:       c.value = 32'sd0;
                default: c.value = -32'sd1;
            endcase
        end else if (roll < 55) begin
            c.value = int'($urandom_range(16)) - 8;
        end else begin
            c.value = $urandom;
        end
        return c;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic signed [31:0] val,
                           input logic known, input logic [1:0] st,
                           input int pos, input int cnt);
        t_step_row row;
        row.cmd.opcode   = op;
        row.cmd.value    = val;
        row.known        = known;
        row.res.status   = st;
        row.res.position = pos[POS_W-1:0];
        row.res.count    = cnt[OUT_CW-1:0];
        directed_rows.push_back(row);
    endtask

    task automatic send_cmd(input t_cmd c, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: result beat with nothing expected: status %0d pos %0d count %0d",
                             $realtime, o_res.status, o_res.position, o_res.count);
            end else begin
                head_res = pending_results.pop_front();
                if (o_res.status !== head_res.status || o_res.position !== head_res.position ||
                    o_res.count !== head_res.count) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: mismatch: expected status %0d pos %0d count %0d, got status %0d pos %0d count %0d",
                                 $realtime, head_res.status, head_res.position, head_res.count,
                                 o_res.status, o_res.position, o_res.count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("sorted_list_insert_remove_search test failed");
                $finish;
            end
        end
    end

    initial begin
        t_res pred;
        t_cmd c;
        int   idle_pct;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_cmd    = '0;
        list_len = 0;
        filling  = 1'b1;

        add_row(OP_SEARCH, 32'sd0,   1'b1, ST_NOT_FOUND, 0, 0);
        add_row(OP_REMOVE, 32'sd5,   1'b1, ST_NOT_FOUND, 0, 0);
        add_row(OP_UNUSED, 32'sd0,   1'b1, ST_NOT_FOUND, 0, 0);
        add_row(OP_INSERT, VAL_MAX,  1'b1, ST_OK,        0, 1);
        add_row(OP_INSERT, VAL_MIN,  1'b1, ST_OK,        0, 2);
        add_row(OP_INSERT, 32'sd0,   1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, -32'sd1,  1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, 32'sd0,   1'b0, ST_OK,        0, 0);
        add_row(OP_SEARCH, 32'sd0,   1'b0, ST_OK,        0, 0);
        add_row(OP_UNUSED, -32'sd1,  1'b0, ST_OK,        0, 0);
        add_row(OP_REMOVE, 32'sd0,   1'b0, ST_OK,        0, 0);
        add_row(OP_REMOVE, 32'sd7,   1'b1, ST_NOT_FOUND, 0, 4);
        add_row(OP_INSERT, 32'sd1,   1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, 32'sd1,   1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, -32'sd5,  1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, 32'sd100, 1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, 32'sh4000_0000, 1'b0, ST_OK,  0, 0);
        add_row(OP_INSERT, 32'shC000_0000, 1'b0, ST_OK,  0, 0);
        add_row(OP_INSERT, 32'sd7,   1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, -32'sd7,  1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, 32'sd3,   1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, 32'sd2,   1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, -32'sd100, 1'b0, ST_OK,       0, 0);
        add_row(OP_INSERT, 32'sd55,  1'b0, ST_OK,        0, 0);
        add_row(OP_INSERT, 32'sd42,  1'b1, ST_FULL,      0, 16);
        add_row(OP_REMOVE, VAL_MIN,  1'b1, ST_OK,        0, 15);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_cmd(directed_rows[i].cmd, 21);
            pred = predict_list_op(directed_rows[i].cmd);
            pending_results.push_back(directed_rows[i].known ? directed_rows[i].res : pred);
        end
        wait_results_drained();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 21 : (phase == 1) ? 85 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                c = random_cmd();
                send_cmd(c, idle_pct);
                pending_results.push_back(predict_list_op(c));
            end
            wait_results_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("sorted_list_insert_remove_search test passed");
        end else begin
            $display("sorted_list_insert_remove_search test failed");
        end
        $finish;
    end

endmodule
